>>> rtl/tlcc_pkg.sv
// ----------------------------------------------------------------------------
// tlcc_pkg
// Shared constants, codes and row sizing for the two-level cache controller.
// ----------------------------------------------------------------------------
package tlcc_pkg;

   localparam int ADDR_W   = 32;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = 32;
   localparam int DEF_SETS = 16;
   localparam int DEF_WAYS = 8;

   typedef logic [1:0] level_type;

   localparam level_type HIT_L1   = 2'd0;
   localparam level_type HIT_L2   = 2'd1;
   localparam level_type HIT_MISS = 2'd2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // One row per set: the L1 line followed by every L2 way with its rank.
   function automatic int row_width(input int sets, input int ways);
      int tw;
      int wb;
      tw = ADDR_W - $clog2(sets);
      wb = $clog2(ways);
      return (1 + tw + DATA_W) + ways * (1 + tw + DATA_W + wb);
   endfunction

endpackage

>>> rtl/tlcc_row_store.sv
// ----------------------------------------------------------------------------
// tlcc_row_store
// Set-indexed row memory, one write and one read per cycle, registered read.
// A read that meets a write to the same row returns the new row.
// ----------------------------------------------------------------------------
module tlcc_row_store #(
   parameter int SETS  = tlcc_pkg::DEF_SETS,
   parameter int ROW_W = tlcc_pkg::row_width(tlcc_pkg::DEF_SETS, tlcc_pkg::DEF_WAYS)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(SETS)-1:0]  wr_addr,
   input  logic [ROW_W-1:0]         wr_row,
   input  logic                     rd_en,
   input  logic [$clog2(SETS)-1:0]  rd_addr,
   output logic [ROW_W-1:0]         rd_row
);

   logic [ROW_W-1:0] mem [SETS];
   logic [ROW_W-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_row_ff <= wr_row;
         end else begin
            rd_row_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_row = rd_row_ff;

endmodule

>>> rtl/tlcc_lookup.sv
// ----------------------------------------------------------------------------
// tlcc_lookup
// Tag match across L1 and all L2 ways of one set, swap / fill / LRU update,
// and the new row to write back.
// ----------------------------------------------------------------------------
module tlcc_lookup #(
   parameter int SETS = tlcc_pkg::DEF_SETS,
   parameter int WAYS = tlcc_pkg::DEF_WAYS,
   localparam int SET_BITS = $clog2(SETS),
   localparam int ROW_W = tlcc_pkg::row_width(SETS, WAYS)
) (
   input  logic                        opcode,
   input  logic [tlcc_pkg::ADDR_W-1:0] address,
   input  logic [tlcc_pkg::DATA_W-1:0] write_data,
   input  logic [tlcc_pkg::DATA_W-1:0] memory_word,
   input  logic [ROW_W-1:0]            row_in,
   output logic [ROW_W-1:0]            row_out,
   output logic [ROW_W-1:0]            row_reset,
   output tlcc_pkg::level_type         hit_level,
   output logic [tlcc_pkg::DATA_W-1:0] read_data
);

   localparam int TAG_W = tlcc_pkg::ADDR_W - SET_BITS;
   localparam int WB    = $clog2(WAYS);

   typedef struct packed {
      logic                        valid;
      logic [TAG_W-1:0]            tag;
      logic [tlcc_pkg::DATA_W-1:0] word;
   } line_type;

   typedef struct packed {
      line_type        line;
      logic [WB-1:0]   rank;
   } way_type;

   typedef struct packed {
      way_type [WAYS-1:0] ways;
      line_type           l1;
   } row_type;

   row_type          cur;
   row_type          nxt;
   row_type          clr;
   logic [TAG_W-1:0] tag;
   logic             is_write;
   logic             l1_hit;
   logic             l2_hit;
   logic [WB-1:0]    hit_way;
   logic [WB-1:0]    victim;
   logic [WB-1:0]    disp_way;
   logic [WB-1:0]    old_rank;
   logic             do_disp;

   assign cur      = row_in;
   assign tag      = address[tlcc_pkg::ADDR_W-1:SET_BITS];
   assign is_write = (opcode == tlcc_pkg::OP_WRITE);

   // Row after reset: nothing valid, ranks equal to way number.
   always_comb begin
      clr = '0;
      for (int k = 0; k < WAYS; k++) begin
         clr.ways[k].rank = WB'(k);
      end
   end

   always_comb begin
      nxt      = cur;
      l1_hit   = cur.l1.valid && (cur.l1.tag == tag);
      l2_hit   = 1'b0;
      hit_way  = '0;
      victim   = '0;
      // descending scans: the lowest-numbered way wins
      for (int k = WAYS - 1; k >= 0; k--) begin
         if (cur.ways[k].line.valid && (cur.ways[k].line.tag == tag)) begin
            l2_hit  = 1'b1;
            hit_way = WB'(k);
         end
         if (cur.ways[k].rank == '0) begin
            victim = WB'(k);
         end
      end

      disp_way = l2_hit ? hit_way : victim;
      old_rank = cur.ways[disp_way].rank;
      do_disp  = !l1_hit && (l2_hit || !is_write);

      if (do_disp) begin
         for (int k = 0; k < WAYS; k++) begin
            if (cur.ways[k].rank > old_rank) begin
               nxt.ways[k].rank = cur.ways[k].rank - WB'(1);
            end
         end
         nxt.ways[disp_way].line = cur.l1;
         nxt.ways[disp_way].rank = WB'(WAYS - 1);
         nxt.l1.valid = 1'b1;
         nxt.l1.tag   = tag;
         if (is_write) begin
            nxt.l1.word = write_data;
         end else if (l2_hit) begin
            nxt.l1.word = cur.ways[hit_way].line.word;
         end else begin
            nxt.l1.word = memory_word;
         end
      end else if (l1_hit && is_write) begin
         nxt.l1.word = write_data;
      end
   end

   always_comb begin
      if (l1_hit) begin
         hit_level = tlcc_pkg::HIT_L1;
      end else if (l2_hit) begin
         hit_level = tlcc_pkg::HIT_L2;
      end else begin
         hit_level = tlcc_pkg::HIT_MISS;
      end
   end

   assign read_data = is_write ? '0 : nxt.l1.word;
   assign row_out   = nxt;
   assign row_reset = clr;

endmodule

>>> rtl/two_level_cache_controller.sv
// ----------------------------------------------------------------------------
// two_level_cache_controller
// Direct-mapped L1 with an exclusive LRU victim L2, write-through, no
// allocate on write miss, with access and miss counters.
// ----------------------------------------------------------------------------
//  channel   ports                               direction  handshake
//  request   req_opcode/address/write_data/...   in         start & !busy
//  response  rsp_hit_level ... rsp_l2_misses     out        rsp_valid, one cycle
//
//  An accepted word passes the request register and then the response
//  register; a new word can be taken every cycle while busy is low. The read
//  row and write-back go through a single row memory (one row per set);
//  same-set words back to back are forwarded. After reset busy stays high
//  while every row is cleared. The response strobe cannot be stalled.
// ----------------------------------------------------------------------------
module two_level_cache_controller #(
   parameter int SETS = tlcc_pkg::DEF_SETS,  // power of two
   parameter int WAYS = tlcc_pkg::DEF_WAYS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_opcode,
   input  logic        [tlcc_pkg::ADDR_W-1:0] req_address,
   input  logic signed [tlcc_pkg::DATA_W-1:0] req_write_data,
   input  logic signed [tlcc_pkg::DATA_W-1:0] req_memory_word,
   output logic                               rsp_valid,
   output logic        [1:0]                  rsp_hit_level,
   output logic signed [tlcc_pkg::DATA_W-1:0] rsp_read_data,
   output logic                               rsp_mem_write_enable,
   output logic signed [tlcc_pkg::DATA_W-1:0] rsp_mem_write_data,
   output logic        [tlcc_pkg::CNT_W-1:0]  rsp_l1_accesses,
   output logic        [tlcc_pkg::CNT_W-1:0]  rsp_l1_misses,
   output logic        [tlcc_pkg::CNT_W-1:0]  rsp_l2_accesses,
   output logic        [tlcc_pkg::CNT_W-1:0]  rsp_l2_misses
);

   localparam int SET_BITS = $clog2(SETS);
   localparam int ROW_W    = tlcc_pkg::row_width(SETS, WAYS);

   logic                        accept;
   logic                        v1_ff;
   logic                        op_ff;
   logic [tlcc_pkg::ADDR_W-1:0] addr_ff;
   logic [tlcc_pkg::DATA_W-1:0] wdata_ff;
   logic [tlcc_pkg::DATA_W-1:0] mword_ff;

   logic                        clearing_ff;
   logic                        clearing_in;
   logic [SET_BITS-1:0]         clr_idx_ff;

   logic [ROW_W-1:0]            rd_row;
   logic [ROW_W-1:0]            new_row;
   logic [ROW_W-1:0]            rst_row;
   logic                        wr_en;
   logic [SET_BITS-1:0]         wr_addr;
   logic [ROW_W-1:0]            wr_row;

   tlcc_pkg::level_type         level;
   logic [tlcc_pkg::DATA_W-1:0] lk_read_data;

   logic                        rsp_valid_ff;
   tlcc_pkg::level_type         hit_level_ff;
   logic [tlcc_pkg::DATA_W-1:0] read_data_ff;
   logic                        mem_we_ff;
   logic [tlcc_pkg::DATA_W-1:0] mem_wdata_ff;
   logic [tlcc_pkg::CNT_W-1:0]  l1_acc_ff;
   logic [tlcc_pkg::CNT_W-1:0]  l1_miss_ff;
   logic [tlcc_pkg::CNT_W-1:0]  l2_acc_ff;
   logic [tlcc_pkg::CNT_W-1:0]  l2_miss_ff;

   assign busy   = clearing_ff;
   assign accept = start && !busy;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
         mword_ff <= req_memory_word;
      end
   end

   // clearing sweep after reset
   assign clearing_in = clearing_ff && (clr_idx_ff != SET_BITS'(SETS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + SET_BITS'(1);
         end
      end
   end

   assign wr_en   = v1_ff || clearing_ff;
   assign wr_addr = clearing_ff ? clr_idx_ff : addr_ff[SET_BITS-1:0];
   assign wr_row  = clearing_ff ? rst_row : new_row;

   tlcc_row_store #(
      .SETS  (SETS),
      .ROW_W (ROW_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_row  (wr_row),
      .rd_en   (accept),
      .rd_addr (req_address[SET_BITS-1:0]),
      .rd_row  (rd_row)
   );

   tlcc_lookup #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_lookup (
      .opcode      (op_ff),
      .address     (addr_ff),
      .write_data  (wdata_ff),
      .memory_word (mword_ff),
      .row_in      (rd_row),
      .row_out     (new_row),
      .row_reset   (rst_row),
      .hit_level   (level),
      .read_data   (lk_read_data)
   );

   // response register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         l1_acc_ff    <= '0;
         l1_miss_ff   <= '0;
         l2_acc_ff    <= '0;
         l2_miss_ff   <= '0;
      end else begin
         rsp_valid_ff <= v1_ff;
         if (v1_ff) begin
            l1_acc_ff <= l1_acc_ff + tlcc_pkg::CNT_W'(1);
            if (level != tlcc_pkg::HIT_L1) begin
               l1_miss_ff <= l1_miss_ff + tlcc_pkg::CNT_W'(1);
               l2_acc_ff  <= l2_acc_ff + tlcc_pkg::CNT_W'(1);
            end
            if (level == tlcc_pkg::HIT_MISS) begin
               l2_miss_ff <= l2_miss_ff + tlcc_pkg::CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         hit_level_ff <= level;
         read_data_ff <= lk_read_data;
         mem_we_ff    <= (op_ff == tlcc_pkg::OP_WRITE);
         mem_wdata_ff <= (op_ff == tlcc_pkg::OP_WRITE) ? wdata_ff : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit_level        = hit_level_ff;
   assign rsp_read_data        = read_data_ff;
   assign rsp_mem_write_enable = mem_we_ff;
   assign rsp_mem_write_data   = mem_wdata_ff;
   assign rsp_l1_accesses      = l1_acc_ff;
   assign rsp_l1_misses        = l1_miss_ff;
   assign rsp_l2_accesses      = l2_acc_ff;
   assign rsp_l2_misses        = l2_miss_ff;

   // ---------------------------------------------------------------------
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted word produced no response");

   a_no_clear_clash: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !v1_ff)
      else $error("row write-back during clearing sweep");

   a_miss_counts: assert property (@(posedge clock) disable iff (reset)
      l1_miss_ff == l2_acc_ff)
      else $error("L1 miss and L2 access counts diverged");

   a_write_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_write_enable |-> rsp_read_data == '0)
      else $error("write response carries read data");

endmodule
